FILE: src/gcni_pkg.sv
`default_nettype none

package gcni_pkg;

    // Widths fixed by the register map and the item fields
    localparam int MUL_W       = 32;
    localparam int IDX_W       = 30;
    localparam int HW_W        = 31;
    localparam int EXTENT_W    = 30;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_RESULTS = 27;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WORLD_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WORLD_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WORLD_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_EXTENT  = 3'd6;

    // Products the shared multiplier computes for one item, in issue order
    typedef enum logic [2:0] {
        OP_CELL_X,
        OP_CELL_Y,
        OP_CELL_Z,
        OP_AREA,
        OP_ROW,
        OP_PLANE
    } mul_op_t;

endpackage

`default_nettype wire

FILE: src/gcni_mul.sv
`default_nettype none

module gcni_mul (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [gcni_pkg::MUL_W-1:0]        opnd_a,
    input  wire logic [gcni_pkg::MUL_W-1:0]        opnd_b,
    output logic      [2*gcni_pkg::MUL_W-1:0]      prod
);
    import gcni_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= opnd_a * opnd_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: src/grid_cell_neighbour_indexer.sv
// Uniform-grid cell indexer. Each accepted item carries a signed Q16.16
// position and a command; the block offsets each axis by the half-world
// register, scales it by the inverse cell size, floors and clamps it to the
// grid, and returns the flat index x + y*(nx+1) + z*(ny+1)*(nx+1) (modulo
// 2^30). Command 0 returns one beat, the own cell; command 1 returns every
// cell of the 3x3x3 block around it clipped to the grid, x outermost and z
// innermost, with last on the final beat. All products go through one
// registered 32x32 multiplier, six products per item, each with an issue
// state and a write state; the first result beat follows the sixth write,
// then one beat per cycle while m_ready is high (up to 27 beats); s_ready is
// low from acceptance until the last beat is taken. Write configuration only
// while the block is idle.
`default_nettype none

module grid_cell_neighbour_indexer #(
    parameter int CELL_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [gcni_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gcni_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_cmd,
    input  wire logic signed [31:0]                  s_pos_x,
    input  wire logic signed [31:0]                  s_pos_y,
    input  wire logic signed [31:0]                  s_pos_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [gcni_pkg::IDX_W-1:0]          m_flat_index,
    output logic                                     m_last
);
    import gcni_pkg::*;

    localparam int EXT_W = 3 * CELL_BITS + EXTENT_W;

    typedef logic [CELL_BITS-1:0] cell_t;
    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WRITE, ST_EMIT} state_t;

    function automatic mul_op_t next_op(input mul_op_t op);
        mul_op_t nxt;
        unique case (op)
            OP_CELL_X: nxt = OP_CELL_Y;
            OP_CELL_Y: nxt = OP_CELL_Z;
            OP_CELL_Z: nxt = OP_AREA;
            OP_AREA:   nxt = OP_ROW;
            OP_ROW:    nxt = OP_PLANE;
            default:   nxt = OP_CELL_X;
        endcase
        return nxt;
    endfunction

    // Configuration registers
    logic [HW_W-1:0]     half_world_reg [3];
    logic [MUL_W-1:0]    inv_cell_reg   [3];
    logic [EXTENT_W-1:0] grid_extent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                half_world_reg[a] <= '0;
                inv_cell_reg[a]   <= MUL_W'(65536);
            end
            grid_extent_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HALF_WORLD_X: half_world_reg[0] <= cfg_wdata[HW_W-1:0];
                CFG_HALF_WORLD_Y: half_world_reg[1] <= cfg_wdata[HW_W-1:0];
                CFG_HALF_WORLD_Z: half_world_reg[2] <= cfg_wdata[HW_W-1:0];
                CFG_INV_CELL_X:   inv_cell_reg[0]   <= cfg_wdata[MUL_W-1:0];
                CFG_INV_CELL_Y:   inv_cell_reg[1]   <= cfg_wdata[MUL_W-1:0];
                CFG_INV_CELL_Z:   inv_cell_reg[2]   <= cfg_wdata[MUL_W-1:0];
                CFG_GRID_EXTENT:  grid_extent_reg   <= cfg_wdata[EXTENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-axis maximum cell index and row/plane strides
    logic [EXT_W-1:0]   extent_ext;
    cell_t              axis_max [3];
    logic [CELL_BITS:0] wx;
    logic [CELL_BITS:0] wy;

    assign extent_ext = EXT_W'(grid_extent_reg);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            axis_max[a] = extent_ext[a*CELL_BITS +: CELL_BITS];
        end
    end

    assign wx = {1'b0, axis_max[0]} + 1'b1;
    assign wy = {1'b0, axis_max[1]} + 1'b1;

    // Offset positions; a sum at or below zero lands in cell 0
    logic signed [31:0]    pos      [3];
    logic signed [MUL_W:0] sum_full [3];
    logic [MUL_W-1:0]      sum_clip [3];

    assign pos[0] = s_pos_x;
    assign pos[1] = s_pos_y;
    assign pos[2] = s_pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum_full[a] = $signed({pos[a][31], pos[a]}) + $signed({2'b00, half_world_reg[a]});
            sum_clip[a] = (sum_full[a][MUL_W] || (sum_full[a] == '0)) ?
                          '0 : sum_full[a][MUL_W-1:0];
        end
    end

    // Sequencer and walk state
    state_t             state_reg;
    mul_op_t            op_reg;
    logic               cmd_reg;
    logic [MUL_W-1:0]   sum_reg  [3];
    cell_t              c_reg    [3];
    cell_t              lo_reg   [3];
    cell_t              hi_reg   [3];
    logic [IDX_W-1:0]   wxy_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   base_x_reg;
    logic [IDX_W-1:0]   base_y_reg;
    cell_t              xw_reg;
    cell_t              yw_reg;
    cell_t              zw_reg;

    // Shared multiplier
    logic               mul_en;
    logic [MUL_W-1:0]   opnd_a;
    logic [MUL_W-1:0]   opnd_b;
    logic [2*MUL_W-1:0] prod;
    logic [MUL_W-1:0]   prod_hi;

    cell_t              anc [3];
    logic [1:0]         wb_axis;
    cell_t              cell_new;
    logic [IDX_W-1:0]   flat_new;
    logic               walk_last;

    // Cell that the first beat names: own cell or lower corner of the block
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            anc[a] = cmd_reg ? lo_reg[a] : c_reg[a];
        end
    end

    always_comb begin
        unique case (op_reg)
            OP_CELL_X: begin
                opnd_a = sum_reg[0];
                opnd_b = inv_cell_reg[0];
            end
            OP_CELL_Y: begin
                opnd_a = sum_reg[1];
                opnd_b = inv_cell_reg[1];
            end
            OP_CELL_Z: begin
                opnd_a = sum_reg[2];
                opnd_b = inv_cell_reg[2];
            end
            OP_AREA: begin
                opnd_a = MUL_W'(wx);
                opnd_b = MUL_W'(wy);
            end
            OP_ROW: begin
                opnd_a = MUL_W'(anc[1]);
                opnd_b = MUL_W'(wx);
            end
            OP_PLANE: begin
                opnd_a = MUL_W'(anc[2]);
                opnd_b = MUL_W'(wxy_reg);
            end
            default: begin
                opnd_a = '0;
                opnd_b = '0;
            end
        endcase
    end

    assign mul_en = (state_reg == ST_ISSUE);

    gcni_mul u_mul (
        .aclk   (aclk),
        .en     (mul_en),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .prod   (prod)
    );

    assign prod_hi = prod[2*MUL_W-1:MUL_W];

    always_comb begin
        unique case (op_reg)
            OP_CELL_Y: wb_axis = 2'd1;
            OP_CELL_Z: wb_axis = 2'd2;
            default:   wb_axis = 2'd0;
        endcase
    end

    // Integer part of the Q32.32 product, saturated to the axis maximum
    assign cell_new = (prod_hi > MUL_W'(axis_max[wb_axis])) ?
                      axis_max[wb_axis] : prod_hi[CELL_BITS-1:0];
    assign flat_new = IDX_W'(anc[0]) + row_reg + prod[IDX_W-1:0];

    assign walk_last = !cmd_reg ||
                       ((xw_reg == hi_reg[0]) && (yw_reg == hi_reg[1]) &&
                        (zw_reg == hi_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_CELL_X;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg <= s_cmd;
                        for (int a = 0; a < 3; a++) begin
                            sum_reg[a] <= sum_clip[a];
                        end
                        op_reg    <= OP_CELL_X;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    op_reg    <= next_op(op_reg);
                    state_reg <= ST_ISSUE;
                    unique case (op_reg)
                        OP_CELL_X, OP_CELL_Y, OP_CELL_Z: begin
                            c_reg[wb_axis]  <= cell_new;
                            lo_reg[wb_axis] <= (cell_new == '0) ?
                                               cell_new : cell_t'(cell_new - 1'b1);
                            hi_reg[wb_axis] <= (cell_new < axis_max[wb_axis]) ?
                                               cell_t'(cell_new + 1'b1) : cell_new;
                        end
                        OP_AREA: begin
                            wxy_reg <= prod[IDX_W-1:0];
                        end
                        OP_ROW: begin
                            row_reg <= prod[IDX_W-1:0];
                        end
                        default: begin
                            cur_reg    <= flat_new;
                            base_x_reg <= flat_new;
                            base_y_reg <= flat_new;
                            xw_reg     <= lo_reg[0];
                            yw_reg     <= lo_reg[1];
                            zw_reg     <= lo_reg[2];
                            state_reg  <= ST_EMIT;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (walk_last) begin
                            state_reg <= ST_IDLE;
                        end else if (zw_reg != hi_reg[2]) begin
                            // advance along z: next plane
                            zw_reg  <= cell_t'(zw_reg + 1'b1);
                            cur_reg <= cur_reg + wxy_reg;
                        end else if (yw_reg != hi_reg[1]) begin
                            // advance along y, rewind z
                            yw_reg     <= cell_t'(yw_reg + 1'b1);
                            zw_reg     <= lo_reg[2];
                            base_y_reg <= base_y_reg + IDX_W'(wx);
                            cur_reg    <= base_y_reg + IDX_W'(wx);
                        end else begin
                            // advance along x, rewind y and z
                            xw_reg     <= cell_t'(xw_reg + 1'b1);
                            yw_reg     <= lo_reg[1];
                            zw_reg     <= lo_reg[2];
                            base_x_reg <= base_x_reg + IDX_W'(1);
                            base_y_reg <= base_x_reg + IDX_W'(1);
                            cur_reg    <= base_x_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_EMIT);
    assign m_flat_index = cur_reg;
    assign m_last       = walk_last;

endmodule

`default_nettype wire

FILE: src/gcni_checker.sv
`default_nettype none

module gcni_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [gcni_pkg::IDX_W-1:0]    m_flat_index,
    input wire logic                          m_last
);
    import gcni_pkg::*;

    // Beats delivered so far for the current item
    logic [4:0] beat_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_cnt_reg <= '0;
        end else if (m_valid && m_ready) begin
            beat_cnt_reg <= m_last ? 5'd0 : 5'(beat_cnt_reg + 1'b1);
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accepted item");

    a_no_input_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while results are pending");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flat_index) && $stable(m_last))
        else $error("stalled result beat changed");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("result beat follows the last beat of an item");

    a_beat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> beat_cnt_reg < 5'(MAX_RESULTS - 1))
        else $error("more beats than the 3x3x3 block holds");

endmodule

bind grid_cell_neighbour_indexer gcni_checker u_gcni_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gcni_pkg::*;

    localparam int CELL_BITS    = 10;
    localparam int DIR_ROWS     = 17;
    localparam int DIR_CFG_AT   = 5;
    localparam int ITEM_GOAL    = 230;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 500_000;

    localparam logic CMD_OWN        = 1'b0;
    localparam logic CMD_NEIGHBOURS = 1'b1;

    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } probe_t;

    typedef struct packed {
        probe_t           probe;
        logic             has_fixed;
        logic [IDX_W-1:0] fixed_index;
    } dir_row_t;

    typedef struct packed {
        logic [IDX_W-1:0] flat_index;
        logic             last;
    } cell_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_cmd;
    logic signed [31:0]   s_pos_x;
    logic signed [31:0]   s_pos_y;
    logic signed [31:0]   s_pos_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [IDX_W-1:0]     m_flat_index;
    logic                 m_last;

    // grid settings as the block holds them
    logic [HW_W-1:0]     half_world_q [3];
    logic [MUL_W-1:0]    inv_cell_q [3];
    logic [EXTENT_W-1:0] extent_q;
    logic [IDX_W-1:0]    centre_q;
    logic [IDX_W-1:0]    walk_q;

    // next grid setting to load
    logic [HW_W-1:0]     plan_hw [3];
    logic [MUL_W-1:0]    plan_inv [3];
    logic [EXTENT_W-1:0] plan_ext;
    int                  axis_shift [3];
    int                  axis_ext [3];
    bit                  structured;

    cell_beat_t pending_cells [$];
    dir_row_t   dir_rows [DIR_ROWS];
    int         mismatch_count = 0;
    int         beats_seen = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    bit         steady;

    grid_cell_neighbour_indexer #(
        .CELL_BITS (CELL_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_flat_index (m_flat_index),
        .m_last       (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned axis_top(int axis);
        return longint'(extent_q[axis*CELL_BITS +: CELL_BITS]);
    endfunction

    function automatic longint unsigned cell_of(int axis, logic signed [31:0] pos);
        longint          offset_sum;
        longint unsigned scaled;
        longint unsigned top;
        offset_sum = longint'(pos) + longint'({1'b0, half_world_q[axis]});
        top = axis_top(axis);
        if (offset_sum <= 0)
            return 0;
        scaled = (longint'(offset_sum) * longint'({32'd0, inv_cell_q[axis]})) >> 32;
        return (scaled > top) ? top : scaled;
    endfunction

    function automatic logic [IDX_W-1:0] flat_of(longint unsigned x, longint unsigned y,
                                                 longint unsigned z);
        longint unsigned wx;
        longint unsigned wy;
        longint unsigned lin;
        wx = axis_top(0) + 1;
        wy = axis_top(1) + 1;
        lin = x + y * wx + z * wy * wx;
        return lin[IDX_W-1:0];
    endfunction

    // append one expected beat at the tail of the queue
    task automatic queue_beat(input cell_beat_t beat);
        pending_cells.insert(pending_cells.size(), beat);
    endtask

    task automatic predict_cells(input probe_t p);
        longint unsigned c [3];
        longint unsigned lo [3];
        longint unsigned hi [3];
        c[0] = cell_of(0, p.pos_x);
        c[1] = cell_of(1, p.pos_y);
        c[2] = cell_of(2, p.pos_z);
        for (int a = 0; a < 3; a++) begin
            lo[a] = (c[a] > 0) ? c[a] - 1 : c[a];
            hi[a] = (c[a] + 1 <= axis_top(a)) ? c[a] + 1 : c[a];
        end
        centre_q = flat_of(c[0], c[1], c[2]);
        if (p.cmd == CMD_OWN) begin
            walk_q = centre_q;
            queue_beat({centre_q, 1'b1});
        end else begin
            for (longint unsigned x = lo[0]; x <= hi[0]; x++)
                for (longint unsigned y = lo[1]; y <= hi[1]; y++)
                    for (longint unsigned z = lo[2]; z <= hi[2]; z++) begin
                        walk_q = flat_of(x, y, z);
                        queue_beat({walk_q,
                                    x == hi[0] && y == hi[1] && z == hi[2]});
                    end
        end
    endtask

    // position near a random cell of the current grid, or plain noise
    function automatic logic [31:0] pick_pos(int axis);
        longint span;
        longint p;
        if (!structured || $urandom_range(0, 4) == 0)
            return $urandom();
        span = longint'(1) << (16 + axis_shift[axis]);
        p = (longint'($urandom_range(0, axis_ext[axis] + 2)) - 1) * span
            - longint'({1'b0, half_world_q[axis]});
        if ($urandom_range(0, 3) != 0)
            p += longint'($urandom_range(0, 32'(span - 1)));
        return p[31:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_HALF_WORLD_X: half_world_q[0] = data[HW_W-1:0];
            CFG_HALF_WORLD_Y: half_world_q[1] = data[HW_W-1:0];
            CFG_HALF_WORLD_Z: half_world_q[2] = data[HW_W-1:0];
            CFG_INV_CELL_X:   inv_cell_q[0] = data;
            CFG_INV_CELL_Y:   inv_cell_q[1] = data;
            CFG_INV_CELL_Z:   inv_cell_q[2] = data;
            CFG_GRID_EXTENT:  extent_q = data[EXTENT_W-1:0];
            default: ;
        endcase
    endtask

    // drain the block, then load the planned grid
    task automatic apply_plan();
        s_valid <= 1'b0;
        while (pending_cells.size() != 0 || !s_ready)
            @(posedge aclk);
        write_reg(CFG_HALF_WORLD_X, {1'b0, plan_hw[0]});
        write_reg(CFG_HALF_WORLD_Y, {1'b0, plan_hw[1]});
        write_reg(CFG_HALF_WORLD_Z, {1'b0, plan_hw[2]});
        write_reg(CFG_INV_CELL_X, plan_inv[0]);
        write_reg(CFG_INV_CELL_Y, plan_inv[1]);
        write_reg(CFG_INV_CELL_Z, plan_inv[2]);
        write_reg(CFG_GRID_EXTENT, {2'b00, plan_ext});
        cfg_we <= 1'b0;
    endtask

    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
    endtask

    task automatic offer(input probe_t p, input logic has_fixed, input logic [IDX_W-1:0] fixed);
        s_valid <= 1'b1;
        s_cmd   <= p.cmd;
        s_pos_x <= p.pos_x;
        s_pos_y <= p.pos_y;
        s_pos_z <= p.pos_z;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (has_fixed)
            queue_beat({fixed, 1'b1});
        else
            predict_cells(p);
        items_sent++;
    endtask

    // result side: check each beat, stall on a pattern of its own
    initial begin : sink
        sink_mode_t mode;
        int         mode_left;
        int         tick;
        int         hold_left;
        int         holds_done;
        cell_beat_t want;
        mode_left  = 0;
        tick       = 0;
        hold_left  = 0;
        holds_done = 0;
        mode       = SINK_OPEN;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (m_valid && m_ready) begin
                beats_seen++;
                if (pending_cells.size() == 0) begin
                    $error("unexpected beat: flat_index %0d last %0b", m_flat_index, m_last);
                    mismatch_count++;
                end else begin
                    want = pending_cells.pop_front();
                    if (m_flat_index !== want.flat_index) begin
                        $error("flat_index: expected %0d, actual %0d",
                               want.flat_index, m_flat_index);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            // hold off long enough for the input side to back up
            if (hold_left == 0 && ((holds_done == 0 && beats_seen >= 200) ||
                                   (holds_done == 1 && beats_seen >= 1500))) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: m_ready <= 1'b1;
                    SINK_COIN: m_ready <= 1'($urandom_range(0, 1));
                    default:   m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        probe_t p;
        int     phase_len;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_cmd     <= CMD_OWN;
        s_pos_x   <= '0;
        s_pos_y   <= '0;
        s_pos_z   <= '0;
        for (int a = 0; a < 3; a++) begin
            half_world_q[a] = '0;
            inv_cell_q[a]   = 32'd65536;
        end
        extent_q   = '0;
        centre_q   = '0;
        walk_q     = '0;
        structured = 1'b0;
        steady     = 1'b0;

        // reset grid: every axis has a single cell
        dir_rows[0]  = {CMD_OWN, 32'h0, 32'h0, 32'h0, 1'b1, 30'd0};
        dir_rows[1]  = {CMD_NEIGHBOURS, 32'h0, 32'h0, 32'h0, 1'b1, 30'd0};
        dir_rows[2]  = {CMD_OWN, POS_MAX, POS_MAX, POS_MAX, 1'b1, 30'd0};
        dir_rows[3]  = {CMD_NEIGHBOURS, POS_MIN, POS_MIN, POS_MIN, 1'b1, 30'd0};
        dir_rows[4]  = {CMD_OWN, 32'h1234_5678, 32'hFEDC_BA98, 32'h0001_0000, 1'b1, 30'd0};
        // 16x16x16 grid, unit cells, origin at 8.0 on each axis
        dir_rows[5]  = {CMD_OWN, 32'h0, 32'h0, 32'h0, 1'b1, 30'd2184};
        dir_rows[6]  = {CMD_OWN, POS_MIN, POS_MIN, POS_MIN, 1'b1, 30'd0};
        dir_rows[7]  = {CMD_OWN, POS_MAX, POS_MAX, POS_MAX, 1'b1, 30'd4095};
        dir_rows[8]  = {CMD_OWN, 32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000, 1'b1, 30'd0};
        dir_rows[9]  = {CMD_OWN, 32'hFFF8_0001, 32'hFFF8_0001, 32'hFFF8_0001, 1'b1, 30'd0};
        dir_rows[10] = {CMD_NEIGHBOURS, 32'h0, 32'h0, 32'h0, 1'b0, 30'd0};
        dir_rows[11] = {CMD_NEIGHBOURS, POS_MIN, POS_MIN, POS_MIN, 1'b0, 30'd0};
        dir_rows[12] = {CMD_NEIGHBOURS, POS_MAX, POS_MAX, POS_MAX, 1'b0, 30'd0};
        dir_rows[13] = {CMD_NEIGHBOURS, POS_MIN, 32'h0, POS_MAX, 1'b0, 30'd0};
        dir_rows[14] = {CMD_NEIGHBOURS, 32'hFFF9_0000, 32'h0006_FFFF, 32'h0007_0000, 1'b0, 30'd0};
        dir_rows[15] = {CMD_OWN, 32'h0007_0000, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 30'd0};
        dir_rows[16] = {CMD_NEIGHBOURS, 32'h0003_8000, 32'hFFFC_0001, 32'h0000_0001, 1'b0, 30'd0};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < DIR_ROWS; row++) begin
            if (row == DIR_CFG_AT) begin
                for (int a = 0; a < 3; a++) begin
                    plan_hw[a]  = 31'h0008_0000;
                    plan_inv[a] = 32'd65536;
                end
                plan_ext = {10'd15, 10'd15, 10'd15};
                apply_plan();
            end
            pace();
            offer(dir_rows[row].probe, dir_rows[row].has_fixed, dir_rows[row].fixed_index);
        end

        // largest offsets, scales and grid
        for (int a = 0; a < 3; a++) begin
            plan_hw[a]  = 31'h7FFF_FFFF;
            plan_inv[a] = 32'hFFFF_FFFF;
        end
        plan_ext = 30'h3FFF_FFFF;
        apply_plan();
        repeat (12) begin
            pace();
            p.cmd   = 1'($urandom_range(0, 1));
            p.pos_x = pick_pos(0);
            p.pos_y = pick_pos(1);
            p.pos_z = pick_pos(2);
            offer(p, 1'b0, '0);
        end

        // no offset and zero scale: every position maps to the corner cell
        for (int a = 0; a < 3; a++) begin
            plan_hw[a]  = '0;
            plan_inv[a] = '0;
        end
        apply_plan();
        repeat (8) begin
            pace();
            p.cmd   = 1'($urandom_range(0, 1));
            p.pos_x = pick_pos(0);
            p.pos_y = pick_pos(1);
            p.pos_z = pick_pos(2);
            offer(p, 1'b0, '0);
        end

        while (items_sent < ITEM_GOAL) begin
            structured = ($urandom_range(0, 4) != 0);
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            if (structured) begin
                for (int a = 0; a < 3; a++) begin
                    longint hw_top;
                    axis_shift[a] = $urandom_range(0, 6);
                    case ($urandom_range(0, 5))
                        0:       axis_ext[a] = 0;
                        4:       axis_ext[a] = $urandom_range(5, 20);
                        5:       axis_ext[a] = 1023;
                        default: axis_ext[a] = $urandom_range(1, 4);
                    endcase
                    plan_inv[a] = ($urandom_range(0, 9) == 0) ? 32'd0
                                                              : 32'd1 << (16 - axis_shift[a]);
                    hw_top = (longint'(axis_ext[a]) + 1) << (16 + axis_shift[a]);
                    if (hw_top > 64'h7FFF_FFFF)
                        hw_top = 64'h7FFF_FFFF;
                    plan_hw[a] = 31'($urandom_range(0, 32'(hw_top)));
                end
                plan_ext = {10'(axis_ext[2]), 10'(axis_ext[1]), 10'(axis_ext[0])};
            end else begin
                for (int a = 0; a < 3; a++) begin
                    plan_hw[a]  = 31'($urandom());
                    plan_inv[a] = $urandom();
                end
                plan_ext = 30'($urandom());
            end
            apply_plan();
            phase_len = $urandom_range(15, 35);
            if (phase_len > ITEM_GOAL - items_sent)
                phase_len = ITEM_GOAL - items_sent;
            repeat (phase_len) begin
                pace();
                p.cmd   = ($urandom_range(0, 1) != 0) ? CMD_NEIGHBOURS : CMD_OWN;
                p.pos_x = pick_pos(0);
                p.pos_y = pick_pos(1);
                p.pos_z = pick_pos(2);
                offer(p, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
